@@ design/sas_pkg.sv @@
// ----------------------------------------------------------------------------
// sas_pkg
// shared types and constants of the sprite animation sequencer
// ----------------------------------------------------------------------------
package sas_pkg;

	// default sizes
	localparam int FRAME_SLOTS_DEF  = 256;
	localparam int ANIM_SLOTS_DEF   = 16;
	localparam int QUEUE_DEPTH_DEF  = 8;
	localparam int MIN_FRAME_MS_DEF = 16;

	// fixed frame time after reset
	localparam logic [15:0] FIXED_MS_RESET = 16'd1000;

	// configuration register indexes
	localparam logic [1:0] REG_PAUSED    = 2'd0;
	localparam logic [1:0] REG_FIXED     = 2'd1;
	localparam logic [1:0] REG_FIXED_MS  = 2'd2;
	localparam logic [1:0] REG_REST      = 2'd3;

	typedef enum logic [2:0] {
		OP_TICK   = 3'd0,
		OP_PLAY   = 3'd1,
		OP_QFRONT = 3'd2,
		OP_QBACK  = 3'd3,
		OP_CLEAR  = 3'd4,
		OP_WDUR   = 3'd5,
		OP_WANIM  = 3'd6
	} opcode_t;

	typedef struct packed {
		logic        paused;
		logic        fixed_timing;
		logic [15:0] fixed_ms;
		logic [7:0]  rest;
	} cfg_t;

	// queue commands, at most one per cycle
	typedef struct packed {
		logic       ins_head;
		logic       ins_tail;
		logic       pop;
		logic       clear;
		logic [3:0] anim;
	} q_cmd_t;

	typedef struct packed {
		logic       empty;
		logic       full;
		logic [3:0] head_anim;
	} q_stat_t;

	// table writes, range checks done in the store
	typedef struct packed {
		logic        dur_we;
		logic [7:0]  slot;
		logic [15:0] dur;
		logic        anim_we;
		logic [3:0]  anim;
		logic [7:0]  beg;
		logic [7:0]  len;
	} tbl_wr_t;

	typedef struct packed {
		logic [15:0] dur;
		logic [7:0]  beg;
		logic [7:0]  len;
	} tbl_rd_t;

endpackage

@@ design/sprite_animation_sequencer_top.sv @@
// ----------------------------------------------------------------------------
// sprite_animation_sequencer_top
// plays a queue of animations over a frame store, one word per command
// ----------------------------------------------------------------------------
// queue, clear, table writes, paused ticks and ticks on an empty queue give
//   their result word in the cycle after start; play passes through ST_PLAY;
//   a playing tick through ST_TICK, and ST_SWITCH when it switches to the
//   next animation; a new command is taken only while not busy, and a tick
//   or play stays busy on the registered duration, animation and queue reads
// reset: arst_n resets queue pointers, playback state and registers at once;
//   table and queue contents stay unknown until written
// the result word is shown for one cycle with done and cannot be stalled
// ----------------------------------------------------------------------------
module sprite_animation_sequencer_top import sas_pkg::*; #(
	parameter int FRAME_SLOTS  = FRAME_SLOTS_DEF,
	parameter int ANIM_SLOTS   = ANIM_SLOTS_DEF,
	parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
	parameter int MIN_FRAME_MS = MIN_FRAME_MS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// command word
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  opcode,
	input  logic [3:0]  anim_number,
	input  logic [7:0]  frame_slot,
	input  logic [15:0] duration_ms,
	input  logic [7:0]  anim_frames,
	// register writes
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// result word
	output logic        done,
	output logic [7:0]  shown_frame,
	output logic [3:0]  active_anim,
	output logic [3:0]  queued,
	output logic        dropped
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	cfg_t          cfg_q;
	q_cmd_t        qc;
	q_stat_t       qs;
	tbl_wr_t       tw;
	tbl_rd_t       rd;
	logic [7:0]    dur_raddr;
	logic [3:0]    anim_raddr;
	logic [CW-1:0] q_count;

	// configuration registers; the fixed frame time is clamped from below
	// to the minimum frame time as it is written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.paused       <= 1'b0;
			cfg_q.fixed_timing <= 1'b0;
			cfg_q.fixed_ms     <= FIXED_MS_RESET;
			cfg_q.rest         <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PAUSED:   cfg_q.paused       <= cfg_data[0];
				REG_FIXED:    cfg_q.fixed_timing <= cfg_data[0];
				REG_FIXED_MS: cfg_q.fixed_ms     <= (cfg_data > 16'(MIN_FRAME_MS)) ?
				                                    cfg_data : 16'(MIN_FRAME_MS);
				REG_REST:     cfg_q.rest         <= cfg_data[7:0];
				default:      cfg_q <= cfg_q;
			endcase
		end
	end

	// sequencer: one command at a time, waits out the memory read latency
	sas_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.opcode      (opcode),
		.anim_number (anim_number),
		.frame_slot  (frame_slot),
		.duration_ms (duration_ms),
		.anim_frames (anim_frames),
		.cfg         (cfg_q),
		.qs          (qs),
		.rd          (rd),
		.qc          (qc),
		.tw          (tw),
		.dur_raddr   (dur_raddr),
		.anim_raddr  (anim_raddr),
		.busy        (busy),
		.done        (done),
		.shown_frame (shown_frame),
		.active_anim (active_anim),
		.dropped     (dropped)
	);

	// duration and animation tables
	sas_store #(
		.FRAME_SLOTS (FRAME_SLOTS),
		.ANIM_SLOTS  (ANIM_SLOTS)
	) u_store (
		.clk        (clk),
		.wr         (tw),
		.dur_raddr  (dur_raddr),
		.anim_raddr (anim_raddr),
		.rd         (rd)
	);

	// play queue with head and fill count
	sas_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (qc),
		.stat   (qs),
		.count  (q_count)
	);

	// fill count already reflects the command whose word is being shown
	assign queued = 4'(q_count);

endmodule

@@ design/sas_store.sv @@
// ----------------------------------------------------------------------------
// sas_store
// frame duration memory and animation begin/length memory, registered reads
// ----------------------------------------------------------------------------
module sas_store import sas_pkg::*; #(
	parameter int FRAME_SLOTS = FRAME_SLOTS_DEF,
	parameter int ANIM_SLOTS  = ANIM_SLOTS_DEF
) (
	input  logic       clk,
	input  tbl_wr_t    wr,
	input  logic [7:0] dur_raddr,
	input  logic [3:0] anim_raddr,
	output tbl_rd_t    rd
);

	localparam int FA = $clog2(FRAME_SLOTS);
	localparam int AA = (ANIM_SLOTS > 1) ? $clog2(ANIM_SLOTS) : 1;

	logic [15:0]   dur_mem [FRAME_SLOTS];
	logic [15:0]   anim_mem [ANIM_SLOTS];
	logic [FA-1:0] slot_of [256];
	logic [15:0]   dur_rd_q;
	logic [15:0]   anim_rd_q;
	logic          anim_ok_q;

	// position to frame address, worked out at elaboration
	for (genvar i = 0; i < 256; i++) begin : g_mod
		assign slot_of[i] = FA'(i % FRAME_SLOTS);
	end

	always_ff @(posedge clk) begin
		if (wr.dur_we && (32'(wr.slot) < FRAME_SLOTS)) begin
			dur_mem[FA'(wr.slot)] <= wr.dur;
		end
		if (wr.anim_we && (32'(wr.anim) < ANIM_SLOTS)) begin
			anim_mem[AA'(wr.anim)] <= {wr.beg, wr.len};
		end
		dur_rd_q  <= dur_mem[slot_of[dur_raddr]];
		anim_rd_q <= anim_mem[AA'(anim_raddr)];
		anim_ok_q <= 32'(anim_raddr) < ANIM_SLOTS;
	end

	// animations beyond the table read as empty at frame zero
	assign rd.dur = dur_rd_q;
	assign rd.beg = anim_ok_q ? anim_rd_q[15:8] : 8'd0;
	assign rd.len = anim_ok_q ? anim_rd_q[7:0] : 8'd0;

endmodule

@@ design/sas_queue.sv @@
// ----------------------------------------------------------------------------
// sas_queue
// circular play queue in a small memory, head entry read every cycle
// ----------------------------------------------------------------------------
module sas_queue import sas_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  q_cmd_t        cmd,
	output q_stat_t       stat,
	output logic [CW-1:0] count
);

	localparam int QA = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int SW = QA + 1;

	logic [3:0]    mem [QUEUE_DEPTH];
	logic [3:0]    head_rd_q;
	logic [QA-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [QA-1:0] head_inc;
	logic [QA-1:0] head_dec;
	logic [SW-1:0] tail_sum;
	logic [QA-1:0] tail;
	logic          full;

	assign full     = count_q >= CW'(QUEUE_DEPTH);
	assign head_inc = (head_q == QA'(QUEUE_DEPTH - 1)) ? '0 : head_q + QA'(1);
	assign head_dec = (head_q == '0) ? QA'(QUEUE_DEPTH - 1) : head_q - QA'(1);
	assign tail_sum = SW'(head_q) + SW'(count_q);
	assign tail     = (tail_sum >= SW'(QUEUE_DEPTH)) ? QA'(tail_sum - SW'(QUEUE_DEPTH))
	                                                 : QA'(tail_sum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (cmd.clear) begin
			count_q <= '0;
		end else if (cmd.ins_head && !full) begin
			head_q  <= head_dec;
			count_q <= count_q + CW'(1);
		end else if (cmd.ins_tail && !full) begin
			count_q <= count_q + CW'(1);
		end else if (cmd.pop && (count_q != '0)) begin
			head_q  <= head_inc;
			count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ins_head && !full) begin
			mem[head_dec] <= cmd.anim;
		end else if (cmd.ins_tail && !full) begin
			mem[tail] <= cmd.anim;
		end
		head_rd_q <= mem[head_q];
	end

	assign stat.empty     = count_q == '0;
	assign stat.full      = full;
	assign stat.head_anim = head_rd_q;
	assign count          = count_q;

endmodule

@@ design/sas_ctrl.sv @@
// ----------------------------------------------------------------------------
// sas_ctrl
// command sequencer: issues table reads and writes and queue commands, evaluates timing, updates playback
// ----------------------------------------------------------------------------
module sas_ctrl import sas_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [2:0] opcode,
	input  logic [3:0] anim_number,
	input  logic [7:0] frame_slot,
	input  logic [15:0] duration_ms,
	input  logic [7:0] anim_frames,
	input  cfg_t       cfg,
	input  q_stat_t    qs,
	input  tbl_rd_t    rd,
	output q_cmd_t     qc,
	output tbl_wr_t    tw,
	output logic [7:0] dur_raddr,
	output logic [3:0] anim_raddr,
	output logic       busy,
	output logic       done,
	output logic [7:0] shown_frame,
	output logic [3:0] active_anim,
	output logic       dropped
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TICK,
		ST_SWITCH,
		ST_PLAY
	} state_t;

	state_t      state_q;
	logic        done_q;
	logic        dropped_q;
	logic [7:0]  draw_q;
	logic [3:0]  cur_q;
	logic [3:0]  play_anim_q;
	logic        need_sw_q;
	logic [15:0] elapsed_q;

	logic        accept;
	logic [15:0] elapsed_inc;
	logic [15:0] limit;
	logic        expired;
	logic [7:0]  base;
	logic [8:0]  end_pos;
	logic [8:0]  next_pos;
	logic        at_end;

	assign accept      = start && (state_q == ST_IDLE);
	assign elapsed_inc = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;
	assign limit       = cfg.fixed_timing ? cfg.fixed_ms : rd.dur;
	assign expired     = elapsed_q > limit;

	// advance from the current frame, or from the begin frame after a switch
	assign base     = (state_q == ST_SWITCH) ? rd.beg : draw_q;
	assign end_pos  = {1'b0, rd.beg} + {1'b0, rd.len};
	assign next_pos = {1'b0, base} + 9'd1;
	assign at_end   = next_pos >= end_pos;

	always_comb begin
		qc.ins_head = accept && (opcode == OP_QFRONT);
		qc.ins_tail = accept && (opcode == OP_QBACK);
		qc.clear    = accept && (opcode == OP_CLEAR);
		qc.anim     = anim_number;
		qc.pop      = ((state_q == ST_TICK) && expired && !need_sw_q && at_end) ||
		              ((state_q == ST_SWITCH) && at_end) ||
		              (state_q == ST_PLAY);
	end

	always_comb begin
		tw.dur_we  = accept && (opcode == OP_WDUR);
		tw.slot    = frame_slot;
		tw.dur     = duration_ms;
		tw.anim_we = accept && (opcode == OP_WANIM);
		tw.anim    = anim_number;
		tw.beg     = frame_slot;
		tw.len     = anim_frames;
	end

	always_comb begin
		dur_raddr = draw_q;
		case (state_q)
			ST_IDLE:  anim_raddr = (opcode == OP_PLAY) ? anim_number : cur_q;
			ST_TICK:  anim_raddr = qs.head_anim;
			default:  anim_raddr = cur_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			done_q      <= 1'b0;
			dropped_q   <= 1'b0;
			draw_q      <= '0;
			cur_q       <= '0;
			play_anim_q <= '0;
			need_sw_q   <= 1'b1;
			elapsed_q   <= '0;
		end else begin
			done_q    <= 1'b0;
			dropped_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						case (opcode_t'(opcode))
							OP_TICK: begin
								if (cfg.paused) begin
									done_q <= 1'b1;
								end else begin
									elapsed_q <= elapsed_inc;
									if (qs.empty) begin
										draw_q <= cfg.rest;
										done_q <= 1'b1;
									end else begin
										state_q <= ST_TICK;
									end
								end
							end
							OP_PLAY: begin
								play_anim_q <= anim_number;
								state_q     <= ST_PLAY;
							end
							OP_QFRONT, OP_QBACK: begin
								dropped_q <= qs.full;
								done_q    <= 1'b1;
							end
							OP_CLEAR: begin
								need_sw_q <= 1'b1;
								done_q    <= 1'b1;
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				ST_TICK: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
					if (expired) begin
						elapsed_q <= '0;
						if (need_sw_q) begin
							cur_q     <= qs.head_anim;
							need_sw_q <= 1'b0;
							state_q   <= ST_SWITCH;
							done_q    <= 1'b0;
						end else if (at_end) begin
							need_sw_q <= 1'b1;
						end else begin
							draw_q <= next_pos[7:0];
						end
					end
				end
				ST_SWITCH: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
					if (at_end) begin
						draw_q    <= rd.beg;
						need_sw_q <= 1'b1;
					end else begin
						draw_q <= next_pos[7:0];
					end
				end
				ST_PLAY: begin
					state_q   <= ST_IDLE;
					done_q    <= 1'b1;
					cur_q     <= play_anim_q;
					draw_q    <= rd.beg;
					need_sw_q <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy        = state_q != ST_IDLE;
	assign done        = done_q;
	assign dropped     = dropped_q;
	assign shown_frame = draw_q;
	assign active_anim = cur_q;

endmodule

@@ design/sas_checker.sv @@
// ----------------------------------------------------------------------------
// sas_checker
// port level checks of the sprite animation sequencer
// ----------------------------------------------------------------------------
module sas_checker import sas_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [2:0] opcode,
	input logic       done,
	input logic [3:0] queued,
	input logic       dropped
);

	// a result word always ends the command
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	// queue and clear commands answer in the next cycle
	a_fast_ops: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (opcode == OP_QFRONT || opcode == OP_QBACK ||
		 opcode == OP_CLEAR)) |=> done)
		else $error("queue command without result word");

	// only a push can be dropped
	a_drop_push: assert property (@(posedge clk) disable iff (!arst_n)
		dropped |-> (done && ($past(opcode) == OP_QFRONT || $past(opcode) == OP_QBACK)))
		else $error("dropped flag without push");

	// fill count shown with a result word never passes a queue depth below 16
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((QUEUE_DEPTH > 15) || (32'(queued) <= QUEUE_DEPTH)))
		else $error("queue count beyond depth");

	// a command that goes busy shows no word on its first busy cycle
	a_busy_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> !done)
		else $error("word shown as busy rose");

endmodule

bind sprite_animation_sequencer_top sas_checker #(
	.QUEUE_DEPTH (QUEUE_DEPTH)
) u_sas_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.opcode  (opcode),
	.done    (done),
	.queued  (queued),
	.dropped (dropped)
);
